FILE: design/cdcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcs_pkg
// Shared types and constants for the causal depthwise convolution step block.
// ----------------------------------------------------------------------------
package cdcs_pkg;

   // Fixed field widths
   localparam int VALUE_W   = 16;
   localparam int CHANNEL_W = 10;
   localparam int TAP_IDX_W = 3;
   localparam int COUNT_W   = 11;
   localparam int POS_W     = 3;
   localparam int FRAC_BITS = 12;
   localparam int PROD_W    = 2 * VALUE_W;

   // Register reset value and saturation limits
   localparam logic [COUNT_W-1:0]        CFG_RESET = 11'd1024;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

   // Item command codes
   typedef enum logic {
      CMD_TAP_WRITE = 1'b0,
      CMD_SAMPLE    = 1'b1
   } command_type;

   // Start-up sequencer
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   typedef logic [VALUE_W-1:0] lane_type;

   // Sample transaction as it travels down the pipeline
   typedef struct packed {
      logic [CHANNEL_W-1:0]        channel;
      logic                        token_end;
      logic [POS_W-1:0]            pos;
      logic signed [VALUE_W-1:0]   sample;
   } item_type;

   // Result tag carried alongside the arithmetic
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 token_end;
   } meta_type;

endpackage

FILE: design/cdcs_lane_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcs_lane_ram
// Single-port-write, single-port-read RAM with one row per channel, split into
// 16-bit lanes that can be written individually. Read data is registered.
// ----------------------------------------------------------------------------
module cdcs_lane_ram
   import cdcs_pkg::*;
#(
   parameter int  LANES = 4,
   parameter int  DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [LANES-1:0][VALUE_W-1:0] rd_data,
   input  logic [LANES-1:0]              wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [LANES-1:0][VALUE_W-1:0] wr_data
);

   logic [LANES-1:0][VALUE_W-1:0] mem [DEPTH];
   logic [LANES-1:0][VALUE_W-1:0] rd_data_ff;

   // Read returns the row as it was before a write in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      for (int l = 0; l < LANES; l++) begin
         if (wr_en[l]) begin
            mem[wr_addr][l] <= wr_data[l];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/cdcs_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcs_mac
// Aligns the history row to the ring position, multiplies by the taps, sums,
// rounds and saturates. Three register stages, the last one being the output.
// ----------------------------------------------------------------------------
module cdcs_mac
   import cdcs_pkg::*;
#(
   parameter int  TAPS     = 4,
   localparam int HIST_LEN = TAPS - 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  item_type                         in_item,
   input  logic [HIST_LEN-1:0][VALUE_W-1:0] in_hist,
   input  logic [TAPS-1:0][VALUE_W-1:0]     in_taps,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [VALUE_W-1:0]        out_value,
   output meta_type                         out_meta
);

   localparam int HIDX_W = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
   localparam int SUM_W  = PROD_W + $clog2(TAPS);
   localparam int RND_W  = SUM_W + 1;
   localparam int HALF   = 1 << (FRAC_BITS - 1);

   localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(VALUE_MAX);
   localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(VALUE_MIN);

   logic [POS_W:0]              slot_sum [HIST_LEN];
   logic signed [VALUE_W-1:0]   opa      [TAPS];
   logic signed [PROD_W-1:0]    prod_in  [TAPS];
   logic signed [PROD_W-1:0]    prod_ff  [TAPS];
   meta_type                    p_meta_ff;
   logic                        p_v_ff;
   logic signed [SUM_W-1:0]     sum_in;
   logic signed [SUM_W-1:0]     sum_ff;
   meta_type                    a_meta_ff;
   logic                        a_v_ff;
   logic signed [RND_W-1:0]     rnd;
   logic signed [RND_W-1:0]     scaled;
   logic signed [VALUE_W-1:0]   value_in;
   logic signed [VALUE_W-1:0]   out_value_ff;
   meta_type                    out_meta_ff;
   logic                        out_v_ff;
   logic                        o_adv;
   logic                        a_adv;
   logic                        p_adv;

   // Stage handshake: a stage moves on when it is empty or its successor moves
   assign o_adv    = !out_v_ff || out_ready;
   assign a_adv    = !a_v_ff || o_adv;
   assign p_adv    = !p_v_ff || a_adv;
   assign in_ready = p_adv;

   // Oldest-first alignment of the history row, then the new sample
   always_comb begin
      for (int j = 0; j < HIST_LEN; j++) begin
         slot_sum[j] = (POS_W+1)'(in_item.pos) + (POS_W+1)'(j);
         if (slot_sum[j] >= (POS_W+1)'(HIST_LEN)) begin
            slot_sum[j] = slot_sum[j] - (POS_W+1)'(HIST_LEN);
         end
         opa[j] = $signed(in_hist[slot_sum[j][HIDX_W-1:0]]);
      end
      opa[HIST_LEN] = in_item.sample;
   end

   // One multiplier per tap
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         prod_in[t] = opa[t] * $signed(in_taps[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_adv) begin
         p_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p_adv && in_valid) begin
         prod_ff            <= prod_in;
         p_meta_ff.channel   <= in_item.channel;
         p_meta_ff.token_end <= in_item.token_end;
      end
   end

   // Sum of the products
   always_comb begin
      sum_in = '0;
      for (int t = 0; t < TAPS; t++) begin
         sum_in = sum_in + SUM_W'(prod_ff[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_adv) begin
         a_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && p_v_ff) begin
         sum_ff    <= sum_in;
         a_meta_ff <= p_meta_ff;
      end
   end

   // Round half up, arithmetic shift back to Q4.12, saturate
   always_comb begin
      rnd    = RND_W'(sum_ff) + RND_W'(HALF);
      scaled = rnd >>> FRAC_BITS;
      priority if (scaled > SAT_HI) begin
         value_in = VALUE_MAX;
      end else if (scaled < SAT_LO) begin
         value_in = VALUE_MIN;
      end else begin
         value_in = scaled[VALUE_W-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (o_adv) begin
         out_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_adv && a_v_ff) begin
         out_value_ff <= value_in;
         out_meta_ff  <= a_meta_ff;
      end
   end

   assign out_valid = out_v_ff;
   assign out_value = out_value_ff;
   assign out_meta  = out_meta_ff;

endmodule

FILE: design/causal_depthwise_conv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_depthwise_conv_step
// Per-channel causal FIR over a token stream, history and taps held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per item. A tap write (command 0) stores one
//            weight and gives no result. A sample (command 1) for a channel
//            below the channel count gives one result on rsp_*; samples for
//            unused channels are dropped.
//   rsp_*  : filtered value (Q4.12, rounded, saturated), its channel and a
//            flag on the last channel of a token.
//   csr_*  : channels_in_use, always ready; write only while the block idles.
// Timing: a sample is registered with its RAM rows in the read stage, then in
//   the product, sum and output registers that drive rsp_*. Throughput: one
//   transaction per cycle while rsp_ready keeps up, set by one history row
//   read and one tap row read per sample, each from its own RAM port.
// Reset: the history RAM is swept to zero, one channel row per cycle;
//   req_ready stays low during the sweep. Tap weights are
//   not cleared and must be written before use.
// Stall: when rsp_ready is low the pipeline fills up to four results and then
//   drops req_ready until the receiver takes one.
// ----------------------------------------------------------------------------
module causal_depthwise_conv_step
   import cdcs_pkg::*;
#(
   parameter int MAX_CHANNELS = 1024,
   parameter int TAPS         = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [CHANNEL_W-1:0]        req_channel,
   input  logic [TAP_IDX_W-1:0]        req_tap_index,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VALUE_W-1:0]   rsp_filtered_value,
   output logic [CHANNEL_W-1:0]        rsp_result_channel,
   output logic                        rsp_token_end,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [COUNT_W-1:0]          csr_channels_in_use
);

   localparam int HIST_LEN = TAPS - 1;
   localparam int CH_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int MAXN_W   = $clog2(MAX_CHANNELS + 1);
   localparam int CNT_W    = (MAXN_W > COUNT_W) ? MAXN_W : COUNT_W;

   localparam logic [CNT_W-1:0]     MAX_N    = CNT_W'(MAX_CHANNELS);
   localparam logic [CH_AW-1:0]     LAST_ROW = CH_AW'(MAX_CHANNELS - 1);
   localparam logic [TAP_IDX_W:0]   TAP_LIM  = (TAP_IDX_W+1)'(TAPS);
   localparam logic [POS_W-1:0]     POS_LAST = POS_W'(HIST_LEN - 1);

   state_type                        state_ff;
   state_type                        state_in;
   logic                             clearing;
   logic [CH_AW-1:0]                 clr_cnt_ff;
   logic [CH_AW-1:0]                 clr_cnt_in;
   logic [COUNT_W-1:0]               csr_ff;
   logic [CNT_W-1:0]                 cfg_ext;
   logic [CNT_W-1:0]                 n_eff;
   logic [CNT_W-1:0]                 ch_ext;
   logic                             accept;
   logic                             is_sample;
   logic                             smp_go;
   logic                             smp_last;
   logic                             tap_go;
   logic [POS_W-1:0]                 ring_pos_ff;
   logic [POS_W-1:0]                 ring_pos_in;
   logic                             s1_v_ff;
   logic                             s1_adv;
   item_type                         s1_item_ff;
   logic                             mac_ready;
   logic [CH_AW-1:0]                 ch_addr;
   logic [HIST_LEN-1:0]              hist_we;
   logic [CH_AW-1:0]                 hist_waddr;
   logic [HIST_LEN-1:0][VALUE_W-1:0] hist_wdata;
   logic [HIST_LEN-1:0][VALUE_W-1:0] hist_rdata;
   logic [TAPS-1:0]                  tap_we;
   logic [TAPS-1:0][VALUE_W-1:0]     tap_wdata;
   logic [TAPS-1:0][VALUE_W-1:0]     tap_rdata;
   meta_type                         rsp_meta;

   // Start-up sweep: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ROW) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Start-up sweep: outputs
   always_comb begin
      unique case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + CH_AW'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Channel count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_ff <= csr_channels_in_use;
      end
   end

   // Effective count: zero counts as one, capped at the RAM depth
   always_comb begin
      cfg_ext = CNT_W'(csr_ff);
      priority if (cfg_ext == '0) begin
         n_eff = CNT_W'(1);
      end else if (cfg_ext > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = cfg_ext;
      end
   end

   // Input decode
   assign s1_adv    = !s1_v_ff || mac_ready;
   assign req_ready = s1_adv && !clearing;
   assign accept    = req_valid && req_ready;
   assign is_sample = (req_command == CMD_SAMPLE);
   assign ch_ext    = CNT_W'(req_channel);
   assign ch_addr   = CH_AW'(req_channel);
   assign smp_go    = accept && is_sample && (ch_ext < n_eff);
   assign smp_last  = (ch_ext == n_eff - CNT_W'(1));
   assign tap_go    = accept && !is_sample && ({1'b0, req_tap_index} < TAP_LIM)
                      && (ch_ext < MAX_N);

   // Shared ring position, advanced by the last channel of a token
   always_comb begin
      ring_pos_in = ring_pos_ff;
      if (smp_go && smp_last) begin
         ring_pos_in = (ring_pos_ff == POS_LAST) ? '0 : ring_pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff <= '0;
      end else begin
         ring_pos_ff <= ring_pos_in;
      end
   end

   // History write: whole rows during the sweep, else the slot at ring position
   always_comb begin
      for (int l = 0; l < HIST_LEN; l++) begin
         hist_we[l]    = clearing || (smp_go && (ring_pos_ff == POS_W'(l)));
         hist_wdata[l] = clearing ? '0 : req_value;
      end
      hist_waddr = clearing ? clr_cnt_ff : ch_addr;
   end

   // Tap write: one lane of the channel row
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         tap_we[t]    = tap_go && (req_tap_index == TAP_IDX_W'(t));
         tap_wdata[t] = req_value;
      end
   end

   cdcs_lane_ram #(
      .LANES (HIST_LEN),
      .DEPTH (MAX_CHANNELS)
   ) u_hist_ram (
      .clock   (clock),
      .rd_en   (smp_go),
      .rd_addr (ch_addr),
      .rd_data (hist_rdata),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata)
   );

   cdcs_lane_ram #(
      .LANES (TAPS),
      .DEPTH (MAX_CHANNELS)
   ) u_tap_ram (
      .clock   (clock),
      .rd_en   (smp_go),
      .rd_addr (ch_addr),
      .rd_data (tap_rdata),
      .wr_en   (tap_we),
      .wr_addr (ch_addr),
      .wr_data (tap_wdata)
   );

   // Read stage: tag travels with the RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_v_ff <= smp_go;
      end
   end

   always_ff @(posedge clock) begin
      if (smp_go) begin
         s1_item_ff.channel   <= req_channel;
         s1_item_ff.token_end <= smp_last;
         s1_item_ff.pos       <= ring_pos_ff;
         s1_item_ff.sample    <= req_value;
      end
   end

   cdcs_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_v_ff),
      .in_ready  (mac_ready),
      .in_item   (s1_item_ff),
      .in_hist   (hist_rdata),
      .in_taps   (tap_rdata),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_value (rsp_filtered_value),
      .out_meta  (rsp_meta)
   );

   assign rsp_result_channel = rsp_meta.channel;
   assign rsp_token_end      = rsp_meta.token_end;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the causal depthwise convolution step block.
// A short table of directed transactions covers the field extremes, both
// commands, ignored tap writes, unused channels and out-of-range channel
// counts. Random traffic follows, mostly whole tokens in channel order with
// random samples and weights. Results are checked against typed table values
// or a predictor with its own history rings, tap weights, ring position and
// channel count. Sender and receiver idle at random, in three phases.
// ----------------------------------------------------------------------------
module testbench;
   import cdcs_pkg::*;

   localparam int MAX_CH    = 1024;
   localparam int TAP_COUNT = 4;
   localparam int HIST_LEN  = TAP_COUNT - 1;
   localparam int RAND_ITEMS = 550;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [CHANNEL_W-1:0]      channel;
      logic                      token_end;
   } conv_result_type;

   typedef enum logic [1:0] {
      ROW_ITEM,      // result, if any, from the predictor
      ROW_CHECKED,   // result typed into the table
      ROW_CSR        // channel count write
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      command_type          cmd;
      logic [CHANNEL_W-1:0] ch;
      logic [TAP_IDX_W-1:0] tap;
      logic [VALUE_W-1:0]   val;
      logic [COUNT_W-1:0]   count;
      logic [VALUE_W-1:0]   want_val;
      logic                 want_end;
   } stim_row_type;

   // DUT connections, all inputs known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   command_type               req_command = CMD_TAP_WRITE;
   logic [CHANNEL_W-1:0]      req_channel = '0;
   logic [TAP_IDX_W-1:0]      req_tap_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_filtered_value;
   logic [CHANNEL_W-1:0]      rsp_result_channel;
   logic                      rsp_token_end;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [COUNT_W-1:0]        csr_channels_in_use = '0;

   // Predictor state
   logic signed [VALUE_W-1:0] hist_mem [MAX_CH][HIST_LEN];
   logic signed [VALUE_W-1:0] tap_mem [MAX_CH][TAP_COUNT];
   logic [TAP_COUNT-1:0]      tap_set [MAX_CH];
   int unsigned               ring_pos;
   logic [COUNT_W-1:0]        chan_count_reg;

   conv_result_type result_q [$];
   stim_row_type    dir_rows [$];
   int unsigned     counted_items = 0;
   int unsigned     error_count = 0;
   int unsigned     send_idle_pct = 9;
   int unsigned     rsp_idle_pct = 81;

   causal_depthwise_conv_step #(
      .MAX_CHANNELS (MAX_CH),
      .TAPS         (TAP_COUNT)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_channel         (req_channel),
      .req_tap_index       (req_tap_index),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_filtered_value  (rsp_filtered_value),
      .rsp_result_channel  (rsp_result_channel),
      .rsp_token_end       (rsp_token_end),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_channels_in_use (csr_channels_in_use)
   );

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Effective channel count: zero reads as one, clamp at the maximum
   function automatic int unsigned active_count();
      if (chan_count_reg == 0) return 1;
      if (chan_count_reg > MAX_CH) return MAX_CH;
      return chan_count_reg;
   endfunction

   // Predict one accepted transaction; returns 1 when it yields a result
   function automatic bit conv_step_model(input command_type cmd,
                                          input logic [CHANNEL_W-1:0] ch,
                                          input logic [TAP_IDX_W-1:0] tap,
                                          input logic signed [VALUE_W-1:0] val,
                                          output conv_result_type res);
      int unsigned n;
      int unsigned pos;
      int unsigned j;
      longint acc;
      longint h;
      longint w;
      longint q;
      n = active_count();
      res = '0;
      if (cmd == CMD_TAP_WRITE) begin
         // taps beyond the filter length are dropped
         if (tap < TAP_COUNT) begin
            tap_mem[ch][tap] = val;
            tap_set[ch][tap] = 1'b1;
         end
         return 1'b0;
      end
      if (ch >= n) return 1'b0;
      pos = ring_pos;
      acc = 0;
      // history oldest first against taps 0..HIST_LEN-1, new sample on the last
      for (j = 0; j < HIST_LEN; j++) begin
         h = hist_mem[ch][(pos + j) % HIST_LEN];
         w = tap_mem[ch][j];
         acc += h * w;
      end
      h = val;
      w = tap_mem[ch][HIST_LEN];
      acc += h * w;
      hist_mem[ch][pos] = val;
      // round half up, then saturate
      q = (acc + 2048) >>> FRAC_BITS;
      if (q > longint'(VALUE_MAX)) q = longint'(VALUE_MAX);
      else if (q < longint'(VALUE_MIN)) q = longint'(VALUE_MIN);
      res.value = VALUE_W'(q);
      res.channel = ch;
      res.token_end = (ch == n - 1);
      if (res.token_end) ring_pos = (pos + 1) % HIST_LEN;
      return 1'b1;
   endfunction

   // Random value: extremes, zero, minus one LSB, values within plus or minus unity, or anything
   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5: return VALUE_W'($urandom_range(8192)) - 16'd4096;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      case ($urandom_range(9))
         0: return '0;
         1: return CFG_RESET;
         2: return COUNT_W'($urandom_range(2047, 1025));
         3: return COUNT_W'($urandom_range(1023, 9));
         default: return COUNT_W'($urandom_range(8, 1));
      endcase
   endfunction

   // Drive one request transaction and record what it should yield
   task automatic push_item(input command_type cmd, input logic [CHANNEL_W-1:0] ch,
                            input logic [TAP_IDX_W-1:0] tap, input logic [VALUE_W-1:0] val,
                            input bit typed, input conv_result_type typed_res);
      conv_result_type res;
      bit              has_res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_channel   <= ch;
      req_tap_index <= tap;
      req_value     <= val;
      do @(posedge clock); while (!req_ready);
      counted_items++;
      has_res = conv_step_model(cmd, ch, tap, val, res);
      if (typed) result_q.push_back(typed_res);
      else if (has_res) result_q.push_back(res);
   endtask

   // Hold off until every result is in, then let tap writes settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_channel_count(input logic [COUNT_W-1:0] count);
      drain_results();
      csr_valid           <= 1'b1;
      csr_channels_in_use <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chan_count_reg = count;
   endtask

   // Sample on a channel, loading its weights first if it is in use and any are still unknown
   task automatic send_sample(input int unsigned ch);
      int unsigned t;
      if (ch < active_count()) begin
         for (t = 0; t < TAP_COUNT; t++) begin
            if (!tap_set[ch][t])
               push_item(CMD_TAP_WRITE, CHANNEL_W'(ch), TAP_IDX_W'(t), rand_value(), 1'b0, '0);
         end
      end
      push_item(CMD_SAMPLE, CHANNEL_W'(ch), TAP_IDX_W'($urandom_range(7)), rand_value(),
                1'b0, '0);
   endtask

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (result_q.size() == 0) begin
            $error("unexpected result transaction, channel %0d", rsp_result_channel);
            error_count++;
         end else begin
            want = result_q.pop_front();
            if (rsp_filtered_value !== want.value) begin
               $error("filtered_value: expected %0d, got %0d",
                      $signed(want.value), rsp_filtered_value);
               error_count++;
            end
            if (rsp_result_channel !== want.channel) begin
               $error("result_channel: expected %0d, got %0d",
                      want.channel, rsp_result_channel);
               error_count++;
            end
            if (rsp_token_end !== want.token_end) begin
               $error("token_end: expected %0d, got %0d", want.token_end, rsp_token_end);
               error_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      stim_row_type    row;
      conv_result_type typed_res;
      int unsigned     base;
      int unsigned     done;
      int unsigned     pick;
      int unsigned     n;
      int unsigned     c;

      // predictor reset state
      foreach (hist_mem[i, k]) hist_mem[i][k] = '0;
      foreach (tap_mem[i, k]) tap_mem[i][k] = '0;
      foreach (tap_set[i]) tap_set[i] = '0;
      ring_pos = 0;
      chan_count_reg = CFG_RESET;

      // kind, command, channel, tap, value, count, expected value, token end
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd0, 16'h1000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd1, 16'h1000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd2, 16'h1000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd3, 16'h1000, 11'd0, 16'h0, 1'b0});
      // history is clear after reset: unity times unity
      dir_rows.push_back('{ROW_CHECKED, CMD_SAMPLE, 10'd0, 3'd0, 16'h1000, 11'd0, 16'h1000,
                           1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd1023, 3'd0, 16'h7FFF, 11'd0, 16'h0,
                           1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd1023, 3'd1, 16'h7FFF, 11'd0, 16'h0,
                           1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd1023, 3'd2, 16'h7FFF, 11'd0, 16'h0,
                           1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd1023, 3'd3, 16'h7FFF, 11'd0, 16'h0,
                           1'b0});
      // max times max saturates; last channel of the full-width token
      dir_rows.push_back('{ROW_CHECKED, CMD_SAMPLE, 10'd1023, 3'd7, 16'h7FFF, 11'd0, 16'h7FFF,
                           1'b1});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd1023, 3'd0, 16'h8000, 11'd0, 16'h0, 1'b0});
      // taps beyond the filter length are ignored
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd4, 16'h7FFF, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd7, 16'h8000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd0, 3'd0, 16'hFFFF, 11'd0, 16'h0, 1'b0});
      // a count of zero reads as one
      dir_rows.push_back('{ROW_CSR, CMD_SAMPLE, 10'd0, 3'd0, 16'h0, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_TAP_WRITE, 10'd0, 3'd3, 16'h8000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd0, 3'd0, 16'h7FFF, 11'd0, 16'h0, 1'b0});
      // unused channels give nothing; then a sample on the one channel in use
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd1, 3'd0, 16'h1234, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd1023, 3'd0, 16'h0, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd0, 3'd5, 16'h8000, 11'd0, 16'h0, 1'b0});
      // counts above the maximum clamp to it
      dir_rows.push_back('{ROW_CSR, CMD_SAMPLE, 10'd0, 3'd0, 16'h0, 11'd2047, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd1023, 3'd0, 16'h8000, 11'd0, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_CSR, CMD_SAMPLE, 10'd0, 3'd0, 16'h0, 11'd1, 16'h0, 1'b0});
      dir_rows.push_back('{ROW_ITEM, CMD_SAMPLE, 10'd0, 3'd0, 16'h0, 11'd0, 16'h0, 1'b0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         typed_res = '{value: row.want_val, channel: row.ch, token_end: row.want_end};
         case (row.kind)
            ROW_CSR: begin
               write_channel_count(row.count);
            end
            ROW_CHECKED: begin
               push_item(row.cmd, row.ch, row.tap, row.val, 1'b1, typed_res);
            end
            default: begin
               push_item(row.cmd, row.ch, row.tap, row.val, 1'b0, '0);
            end
         endcase
      end

      // random traffic in three idling phases
      base = counted_items;
      done = 0;
      while (done < RAND_ITEMS) begin
         send_idle_pct = (done < RAND_ITEMS / 3) ? 9 : (done < 2 * RAND_ITEMS / 3) ? 81 : 0;
         rsp_idle_pct  = (done < RAND_ITEMS / 3) ? 81 : (done < 2 * RAND_ITEMS / 3) ? 9 : 0;
         pick = $urandom_range(99);
         n = active_count();
         if (pick < 6) begin
            write_channel_count(rand_count());
         end else if (pick < 55) begin
            // a whole token in order; long tokens get a few channels and the last
            if (n <= 16) begin
               for (c = 0; c < n; c++) send_sample(c);
            end else begin
               repeat (4) send_sample($urandom_range(7));
               send_sample(n - 1);
            end
         end else if (pick < 70) begin
            push_item(CMD_TAP_WRITE, CHANNEL_W'($urandom_range(MAX_CH - 1)),
                      TAP_IDX_W'($urandom_range(7)), rand_value(), 1'b0, '0);
         end else if (pick < 80) begin
            if (n < MAX_CH) send_sample($urandom_range(MAX_CH - 1, n));
            else send_sample($urandom_range(MAX_CH - 1));
         end else if (pick < 82) begin
            drain_results();
         end else begin
            send_sample($urandom_range(n - 1));
         end
         done = counted_items - base;
      end

      drain_results();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
